// ===== hdl/utli_pkg.sv =====
// Shared types and constants for the uniform-table linear interpolator.
package utli_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [31:0] X_MIN_RST     = 32'd0;
  localparam logic [31:0] X_MAX_RST     = 32'd4128768;
  localparam logic [31:0] INV_STEP_RST  = 32'd65536;
  localparam logic [6:0]  TABLE_LEN_RST = 7'd64;

  typedef enum logic [1:0] {
    CFG_X_MIN     = 2'd0,
    CFG_X_MAX     = 2'd1,
    CFG_INV_STEP  = 2'd2,
    CFG_TABLE_LEN = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ZONE_MID  = 2'd0,
    ZONE_LOW  = 2'd1,
    ZONE_HIGH = 2'd2
  } zone_t;

  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic [31:0]        inv_step;
  } cfg_t;

  typedef struct packed {
    req_kind_t   kind;
    zone_t       zone;
    logic [5:0]  entry_index;
    logic [31:0] data;
  } mid_item_t;

  localparam int MID_WIDTH = $bits(mid_item_t);
  localparam int OUT_WIDTH = 32;

endpackage

// ===== hdl/utli_front.sv =====
// Front end: accepts input beats, classifies lookups against the range and forms the offset.
module utli_front (
  input  logic                in_push,
  input  logic                in_req_type,
  input  logic [5:0]          in_entry_index,
  input  logic signed [31:0]  in_entry_value,
  input  logic signed [31:0]  in_x_value,
  input  utli_pkg::cfg_t      cfg_i,
  input  logic                mid_full_i,
  output logic                in_full,
  output logic                mid_push_o,
  output utli_pkg::mid_item_t mid_item_o
);
  import utli_pkg::*;

  logic signed [32:0] diff;

  assign in_full    = mid_full_i;
  assign mid_push_o = in_push && !mid_full_i;
  assign diff       = 33'(in_x_value) - 33'(cfg_i.x_min);

  always_comb begin
    mid_item_o.kind        = req_kind_t'(in_req_type);
    mid_item_o.entry_index = in_entry_index;
    if (in_x_value >= cfg_i.x_max) begin
      mid_item_o.zone = ZONE_HIGH;
    end else if (in_x_value <= cfg_i.x_min) begin
      mid_item_o.zone = ZONE_LOW;
    end else begin
      mid_item_o.zone = ZONE_MID;
    end
    if (req_kind_t'(in_req_type) == REQ_LOAD) begin
      mid_item_o.data = in_entry_value;
    end else begin
      mid_item_o.data = diff[31:0];
    end
  end

endmodule

// ===== hdl/utli_fifo.sv =====
// Small register FIFO with occupancy count.
module utli_fifo #(
  parameter int WIDTH = utli_pkg::MID_WIDTH,
  parameter int DEPTH = utli_pkg::MID_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign count_o = cnt_r;
  assign rdata_o = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_cnt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("fifo count did not drop on a pop");

endmodule

// ===== hdl/utli_back.sv =====
// Back end: reciprocal multiply, table store, interpolation and saturation pipeline.
module utli_back #(
  parameter int TABLE_DEPTH = utli_pkg::TABLE_DEPTH_DEF,
  parameter int OUT_DEPTH   = utli_pkg::OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  utli_pkg::cfg_t                 cfg_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] last_idx_i,
  input  logic                           mid_empty_i,
  input  utli_pkg::mid_item_t            mid_item_i,
  output logic                           mid_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                           out_push_o,
  output logic [31:0]                    out_data_o
);
  import utli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [31:0] mem_r [TABLE_DEPTH];

  logic        v1_r;
  req_kind_t   kind1_r;
  zone_t       zone1_r;
  logic [5:0]  idx1_r;
  logic [31:0] val1_r;
  logic [63:0] prod1_r;

  logic               v2_r, v3_r, v4_r;
  logic [15:0]        frac2_r, frac3_r;
  logic signed [31:0] rd0_r, rd1_r;
  logic signed [32:0] diff3_r;
  logic signed [31:0] t0_3_r, t0_4_r;
  logic signed [49:0] prod4_r;

  logic [2:0]         inflight;
  logic               issue;
  logic [31:0]        ip;
  logic [AW-1:0]      i0, i1;
  logic [15:0]        frac;
  logic [31:0]        slot_ext;
  logic               wr_en;
  logic signed [34:0] sum;

  assign inflight = 3'(v1_r && kind1_r == REQ_LOOKUP) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r);
  assign issue    = !mid_empty_i &&
                    ((32'(out_count_i) + 32'(inflight)) < 32'(OUT_DEPTH));
  assign mid_pop_o = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r && kind1_r == REQ_LOOKUP;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    kind1_r <= mid_item_i.kind;
    zone1_r <= mid_item_i.zone;
    idx1_r  <= mid_item_i.entry_index;
    val1_r  <= mid_item_i.data;
    prod1_r <= 64'(mid_item_i.data) * 64'(cfg_i.inv_step);
  end

  assign ip = prod1_r[63:32];

  always_comb begin
    unique case (zone1_r)
      ZONE_HIGH: begin
        i0   = last_idx_i;
        i1   = last_idx_i;
        frac = '0;
      end
      ZONE_LOW: begin
        i0   = '0;
        i1   = '0;
        frac = '0;
      end
      default: begin
        i0   = (ip <= 32'(last_idx_i)) ? ip[AW-1:0] : last_idx_i;
        i1   = (i0 < last_idx_i) ? i0 + 1'b1 : last_idx_i;
        frac = prod1_r[31:16];
      end
    endcase
  end

  assign slot_ext = 32'(idx1_r);
  assign wr_en    = v1_r && kind1_r == REQ_LOAD && slot_ext < 32'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[slot_ext[AW-1:0]] <= val1_r;
    end
    rd0_r <= mem_r[i0];
    rd1_r <= mem_r[i1];
  end

  always_ff @(posedge clk) begin
    frac2_r <= frac;
    frac3_r <= frac2_r;
    diff3_r <= 33'(rd1_r) - 33'(rd0_r);
    t0_3_r  <= rd0_r;
    prod4_r <= diff3_r * $signed({1'b0, frac3_r});
    t0_4_r  <= t0_3_r;
  end

  assign sum        = 35'(t0_4_r) + 35'(prod4_r >>> 16);
  assign out_push_o = v4_r;

  always_comb begin
    if (sum > 35'sd2147483647) begin
      out_data_o = 32'h7FFF_FFFF;
    end else if (sum < -35'sd2147483648) begin
      out_data_o = 32'h8000_0000;
    end else begin
      out_data_o = sum[31:0];
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(out_count_i) + 32'(inflight)) <= 32'(OUT_DEPTH))
    else $error("result beats in flight exceed result queue space");

  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && kind1_r == REQ_LOOKUP) |-> (i0 <= last_idx_i && i1 <= last_idx_i && i1 >= i0))
    else $error("table read address outside the entries in use");

endmodule

// ===== hdl/uniform_table_linear_interp_top.sv =====
// Top level of the uniform-table linear interpolator: configuration, front, queues and back.
//
// Input beats are pushed with in_push while in_full is low. A beat with in_req_type 0
// writes in_entry_value into table slot in_entry_index and yields no result; a beat with
// in_req_type 1 looks up in_x_value and yields one result beat on out_y_value.
// Results are read like a queue: out_y_value holds the oldest result while out_empty is
// low, and out_pop takes it. Results leave in the order the lookups entered.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata while no
// work is in flight; they take effect at the next edge.
// A lookup passes the queue behind the front, the four back-end stages and then the result queue.
// Throughput: one beat per cycle of either kind, sustained while results are taken.
// The figure is set by the four-stage back-end pipeline; the table store has one
// write port and two registered read ports, so loads and lookups both pass at that rate.
// Reset clears both queues, the pipeline and the configuration to its defaults; table
// entries hold no defined value until loaded.
// When the receiver stalls, up to eight results wait in the result queue; the back end
// then stops issuing, the four-entry queue behind the front fills, and in_full rises.
module uniform_table_linear_interp_top #(
  parameter int TABLE_DEPTH = utli_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_req_type,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_x_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_y_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import utli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int OCW = $clog2(OUT_DEPTH+1);
  localparam int MCW = $clog2(MID_DEPTH+1);

  logic [31:0] x_min_r, x_max_r, inv_step_r;
  logic [6:0]  table_len_r;
  cfg_t        cfg;
  logic [31:0] len_ext;
  logic [31:0] len_eff;
  logic [AW-1:0] last_idx;

  logic        mid_full, mid_empty, mid_push, mid_pop;
  mid_item_t   mid_in, mid_out;
  logic [MID_WIDTH-1:0] mid_rdata;
  logic [MCW-1:0] mid_count;

  logic        out_push, out_full;
  logic [31:0] out_data, out_rdata;
  logic [OCW-1:0] out_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r     <= X_MIN_RST;
      x_max_r     <= X_MAX_RST;
      inv_step_r  <= INV_STEP_RST;
      table_len_r <= TABLE_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_MIN:     x_min_r     <= cfg_wdata;
        CFG_X_MAX:     x_max_r     <= cfg_wdata;
        CFG_INV_STEP:  inv_step_r  <= cfg_wdata;
        CFG_TABLE_LEN: table_len_r <= cfg_wdata[6:0];
      endcase
    end
  end

  assign cfg.x_min    = x_min_r;
  assign cfg.x_max    = x_max_r;
  assign cfg.inv_step = inv_step_r;

  assign len_ext  = (table_len_r == '0) ? 32'd1 : 32'(table_len_r);
  assign len_eff  = (len_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : len_ext;
  assign last_idx = AW'(len_eff - 32'd1);

  utli_front u_front (
    .in_push        (in_push),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_x_value     (in_x_value),
    .cfg_i          (cfg),
    .mid_full_i     (mid_full),
    .in_full        (in_full),
    .mid_push_o     (mid_push),
    .mid_item_o     (mid_in)
  );

  utli_fifo #(
    .WIDTH (MID_WIDTH),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (mid_push),
    .wdata_i (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  assign mid_out = mid_item_t'(mid_rdata);

  utli_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .last_idx_i  (last_idx),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_data_o  (out_data)
  );

  utli_fifo #(
    .WIDTH (OUT_WIDTH),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (out_push),
    .wdata_i (out_data),
    .full_o  (out_full),
    .pop_i   (out_pop),
    .rdata_o (out_rdata),
    .empty_o (out_empty),
    .count_o (out_count)
  );

  assign out_y_value = out_rdata;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_push && out_full))
    else $error("result beat pushed into a full result queue");

  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_count <= MCW'(MID_DEPTH))
    else $error("middle queue count beyond depth");

endmodule
